### rtl/bpd_pkg.sv
// Shared types and constants of the bit-packed delta decoder.
package bpd_pkg;

	localparam int BLOCK_SIZE = 8;
	localparam int PAIR_SIZE  = 2 * BLOCK_SIZE;

	localparam logic [7:0]        BYTE_ESC16 = 8'd254;
	localparam logic [7:0]        BYTE_ESC32 = 8'd255;
	localparam logic signed [8:0] CODE_OVF16 = 9'sd127;
	localparam logic signed [8:0] CODE_OVF32 = 9'sd128;
	localparam logic [3:0]        MAX_WIDTH  = 4'd8;
	localparam logic [15:0]       DIM_RESET  = 16'd1024;

	localparam logic REG_ROW_WIDTH = 1'b0;
	localparam logic REG_ROW_COUNT = 1'b1;

	typedef enum logic [10:0] {
		PH_FIRST     = 11'b000_0000_0001,
		PH_FIRST_S16 = 11'b000_0000_0010,
		PH_FIRST_S32 = 11'b000_0000_0100,
		PH_WIDTH     = 11'b000_0000_1000,
		PH_BLOCK0    = 11'b000_0001_0000,
		PH_BLOCK1    = 11'b000_0010_0000,
		PH_PAIR_S16  = 11'b000_0100_0000,
		PH_PAIR_S32  = 11'b000_1000_0000,
		PH_TAIL      = 11'b001_0000_0000,
		PH_TAIL_S16  = 11'b010_0000_0000,
		PH_TAIL_S32  = 11'b100_0000_0000
	} phase_t;

	typedef enum logic [5:0] {
		SQ_IDLE   = 6'b00_0001,
		SQ_DECODE = 6'b00_0010,
		SQ_ADV    = 6'b00_0100,
		SQ_UNPACK = 6'b00_1000,
		SQ_RUN    = 6'b01_0000,
		SQ_FLUSH  = 6'b10_0000
	} seq_t;

	typedef struct packed {
		logic [31:0] value;
		logic        eor;
		logic        eoi;
		logic [15:0] pd_next;
		logic [15:0] rd_next;
	} emit_t;

endpackage

### rtl/bpd_unpack_shift.sv
// Shift unit: takes one biased code of n bits off the low end of the gather word.
module bpd_unpack_shift import bpd_pkg::*; (
	input  logic [63:0]       word,
	input  logic [3:0]        width,
	output logic signed [8:0] code,
	output logic [63:0]       word_next
);

	logic [8:0] mask;
	logic [8:0] raw;
	logic [8:0] bias;

	always_comb begin
		mask = (9'd1 << width) - 9'd1;
		raw  = {1'b0, word[7:0] & mask[7:0]};
		if (width > 4'd1) begin
			bias = (9'd1 << (width - 4'd1)) - 9'd1;
		end else begin
			bias = 9'd0;
		end
		code      = $signed(raw - bias);
		word_next = word >> width;
	end

endmodule

### rtl/bpd_emit.sv
// Pixel unit: the shared 32-bit adder plus row and image position tracking.
module bpd_emit import bpd_pkg::*; (
	input  logic [31:0] prev,
	input  logic [31:0] operand,
	input  logic        absolute,
	input  logic [15:0] pixels_done,
	input  logic [15:0] rows_done,
	input  logic [15:0] row_width,
	input  logic [15:0] row_count,
	output emit_t       res
);

	logic [15:0] pd_inc;
	logic [16:0] rd_inc;

	always_comb begin
		pd_inc      = pixels_done + 16'd1;
		rd_inc      = {1'b0, rows_done} + 17'd1;
		res.value   = (absolute ? 32'd0 : prev) + operand;
		res.eor     = pd_inc >= row_width;
		res.eoi     = res.eor && (rd_inc >= {1'b0, row_count});
		res.pd_next = res.eor ? 16'd0 : pd_inc;
		if (!res.eor) begin
			res.rd_next = rows_done;
		end else if (res.eoi) begin
			res.rd_next = 16'd0;
		end else begin
			res.rd_next = rd_inc[15:0];
		end
	end

endmodule

### rtl/block_bitpacked_delta_decoder_unit.sv
// Top level of the bit-packed delta decoder: sequencer, state and stream ports.
//
// Takes compressed rows one byte per beat and emits 32-bit pixels. A byte that
// yields at most one pixel by itself passes through accept, decode and hand-off;
// a code byte of a pair block adds a step to test the block for completion. A
// complete block runs the shared shift unit over its eight codes, then the shared adder
// releases one pixel per cycle while the output slot is free, and a last step finds
// the pair's end or an overflow code. Output backpressure can stall the run.
// The input is not ready while a byte is at work. Configure row_width at 0x0 and
// row_count at 0x4 only while idle.
module block_bitpacked_delta_decoder_unit import bpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] row_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] pixel_value
	output logic        m_tlast,   // last_of_run
	output logic [2:0]  m_tuser    // [0] end_of_row, [1] end_of_image, [2] format_error
);

	seq_t   seq_q, seq_d;
	phase_t ph_q, ph_d, next_sec;

	logic [15:0] rw_q, rc_q;
	logic [15:0] pd_q, pd_d, rd_q, rd_d;
	logic [31:0] prev_q, prev_d;
	logic [4:0]  nte_q, nte_d;
	logic [63:0] gth_q, gth_d, gth_add;
	logic [3:0]  bg_q, bg_d, bg_inc;
	logic [7:0]  bw_q, bw_d, byte_q, byte_d;
	logic [2:0]  unp_cnt_q, unp_cnt_d;
	logic        unp_hi_q, unp_hi_d;
	logic signed [8:0] codes_q [PAIR_SIZE];
	logic signed [8:0] run_code, ext_code;
	logic [63:0] ext_next;
	logic        code_we;
	logic [3:0]  w0c, w1c, ext_w;
	logic        perr;
	logic [31:0] gv16, gv32;
	logic [15:0] rem, rem_base;

	logic        em_fire, em_abs, em_err;
	logic [31:0] em_op;
	emit_t       em;

	logic        pend_valid_q, pend_eor_q, pend_eoi_q, pend_err_q;
	logic [31:0] pend_pix_q;
	logic        out_free, slot_ok, flush_move, move_out;
	logic        out_valid_q, out_last_q, out_eor_q, out_eoi_q, out_err_q;
	logic [31:0] out_pix_q;
	logic        cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = {16'd0, (paddr[2] == REG_ROW_COUNT) ? rc_q : rw_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rw_q <= DIM_RESET;
			rc_q <= DIM_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ROW_WIDTH) begin
				rw_q <= pwdata[15:0];
			end else begin
				rc_q <= pwdata[15:0];
			end
		end
	end

	assign w0c  = (bw_q[3:0] > MAX_WIDTH) ? MAX_WIDTH : bw_q[3:0];
	assign w1c  = (bw_q[7:4] > MAX_WIDTH) ? MAX_WIDTH : bw_q[7:4];
	assign perr = (bw_q[3:0] > MAX_WIDTH) || (bw_q[7:4] > MAX_WIDTH);
	assign ext_w = unp_hi_q ? w1c : w0c;

	assign gth_add = gth_q | ({56'd0, byte_q} << {bg_q[2:0], 3'b000});
	assign bg_inc  = bg_q + 4'd1;
	assign gv16    = {{16{gth_add[15]}}, gth_add[15:0]};
	assign gv32    = gth_add[31:0];
	assign run_code = codes_q[nte_q[3:0]];

	bpd_unpack_shift u_shift (
		.word      (gth_q),
		.width     (ext_w),
		.code      (ext_code),
		.word_next (ext_next)
	);

	bpd_emit u_emit (
		.prev        (prev_q),
		.operand     (em_op),
		.absolute    (em_abs),
		.pixels_done (pd_q),
		.rows_done   (rd_q),
		.row_width   (rw_q),
		.row_count   (rc_q),
		.res         (em)
	);

	assign out_free = !out_valid_q || m_tready;
	assign slot_ok  = !pend_valid_q || out_free;
	assign rem_base = em_fire ? em.pd_next : pd_q;
	assign rem      = rw_q - rem_base;
	assign next_sec = (rem >= 16'(PAIR_SIZE)) ? PH_WIDTH : PH_TAIL;
	assign s_tready = (seq_q == SQ_IDLE);

	always_comb begin
		seq_d     = seq_q;
		ph_d      = ph_q;
		pd_d      = pd_q;
		rd_d      = rd_q;
		prev_d    = prev_q;
		nte_d     = nte_q;
		gth_d     = gth_q;
		bg_d      = bg_q;
		bw_d      = bw_q;
		byte_d    = byte_q;
		unp_cnt_d = unp_cnt_q;
		unp_hi_d  = unp_hi_q;
		code_we   = 1'b0;
		em_fire   = 1'b0;
		em_abs    = 1'b0;
		em_err    = 1'b0;
		em_op     = 32'd0;
		flush_move = 1'b0;
		case (seq_q)
			SQ_IDLE: begin
				if (s_tvalid) begin
					byte_d = s_tdata;
					seq_d  = SQ_DECODE;
					if (s_tuser) begin
						ph_d  = PH_FIRST;
						pd_d  = 16'd0;
						nte_d = 5'd0;
						bw_d  = 8'd0;
						gth_d = 64'd0;
						bg_d  = 4'd0;
					end
				end
			end
			SQ_DECODE: begin
				seq_d = SQ_FLUSH;
				case (ph_q)
					PH_FIRST, PH_TAIL: begin
						if (byte_q == BYTE_ESC16) begin
							ph_d  = (ph_q == PH_FIRST) ? PH_FIRST_S16 : PH_TAIL_S16;
							gth_d = 64'd0;
							bg_d  = 4'd0;
						end else if (byte_q == BYTE_ESC32) begin
							ph_d  = (ph_q == PH_FIRST) ? PH_FIRST_S32 : PH_TAIL_S32;
							gth_d = 64'd0;
							bg_d  = 4'd0;
						end else begin
							em_fire = 1'b1;
							em_abs  = (ph_q == PH_FIRST);
							em_op   = {24'd0, byte_q} - 32'd127;
							ph_d    = next_sec;
							gth_d   = 64'd0;
							bg_d    = 4'd0;
						end
					end
					PH_FIRST_S16, PH_TAIL_S16, PH_FIRST_S32, PH_TAIL_S32: begin
						gth_d = gth_add;
						bg_d  = bg_inc;
						if (((ph_q == PH_FIRST_S16 || ph_q == PH_TAIL_S16) && bg_inc >= 4'd2) ||
						    ((ph_q == PH_FIRST_S32 || ph_q == PH_TAIL_S32) && bg_inc >= 4'd4)) begin
							em_fire = 1'b1;
							em_abs  = (ph_q == PH_FIRST_S16 || ph_q == PH_FIRST_S32);
							em_op   = (ph_q == PH_FIRST_S16 || ph_q == PH_TAIL_S16) ? gv16 : gv32;
							ph_d    = next_sec;
							gth_d   = 64'd0;
							bg_d    = 4'd0;
						end
					end
					PH_WIDTH: begin
						bw_d  = byte_q;
						ph_d  = PH_BLOCK0;
						gth_d = 64'd0;
						bg_d  = 4'd0;
						seq_d = SQ_ADV;
					end
					PH_BLOCK0, PH_BLOCK1: begin
						gth_d = gth_add;
						bg_d  = bg_inc;
						seq_d = SQ_ADV;
					end
					PH_PAIR_S16, PH_PAIR_S32: begin
						gth_d = gth_add;
						bg_d  = bg_inc;
						if ((ph_q == PH_PAIR_S16 && bg_inc >= 4'd2) ||
						    (ph_q == PH_PAIR_S32 && bg_inc >= 4'd4)) begin
							em_fire = 1'b1;
							em_op   = (ph_q == PH_PAIR_S16) ? gv16 : gv32;
							em_err  = perr;
							gth_d   = 64'd0;
							bg_d    = 4'd0;
							ph_d    = PH_BLOCK1;
							nte_d   = nte_q + 5'd1;
							seq_d   = SQ_RUN;
						end
					end
					default: begin
						ph_d  = PH_FIRST;
						gth_d = 64'd0;
						bg_d  = 4'd0;
					end
				endcase
			end
			SQ_ADV: begin
				unp_cnt_d = 3'd0;
				if (ph_q == PH_BLOCK0 && bg_q >= w0c) begin
					unp_hi_d = 1'b0;
					seq_d    = SQ_UNPACK;
				end else if (ph_q == PH_BLOCK1 && bg_q >= w1c) begin
					unp_hi_d = 1'b1;
					seq_d    = SQ_UNPACK;
				end else begin
					seq_d = SQ_FLUSH;
				end
			end
			SQ_UNPACK: begin
				code_we   = 1'b1;
				gth_d     = ext_next;
				unp_cnt_d = unp_cnt_q + 3'd1;
				if (unp_cnt_q == 3'(BLOCK_SIZE - 1)) begin
					gth_d = 64'd0;
					bg_d  = 4'd0;
					if (!unp_hi_q) begin
						ph_d  = PH_BLOCK1;
						seq_d = SQ_ADV;
					end else begin
						nte_d = 5'd0;
						seq_d = SQ_RUN;
					end
				end
			end
			SQ_RUN: begin
				if (nte_q[4]) begin
					nte_d = 5'd0;
					ph_d  = next_sec;
					gth_d = 64'd0;
					bg_d  = 4'd0;
					seq_d = SQ_FLUSH;
				end else if (run_code == CODE_OVF32) begin
					ph_d  = PH_PAIR_S32;
					gth_d = 64'd0;
					bg_d  = 4'd0;
					seq_d = SQ_FLUSH;
				end else if (run_code == CODE_OVF16) begin
					ph_d  = PH_PAIR_S16;
					gth_d = 64'd0;
					bg_d  = 4'd0;
					seq_d = SQ_FLUSH;
				end else if (slot_ok) begin
					em_fire = 1'b1;
					em_op   = {{23{run_code[8]}}, run_code};
					em_err  = perr;
					nte_d   = nte_q + 5'd1;
				end
			end
			SQ_FLUSH: begin
				if (!pend_valid_q) begin
					seq_d = SQ_IDLE;
				end else if (out_free) begin
					flush_move = 1'b1;
					seq_d      = SQ_IDLE;
				end
			end
			default: begin
				seq_d = SQ_IDLE;
			end
		endcase
		if (em_fire) begin
			prev_d = em.value;
			pd_d   = em.pd_next;
			rd_d   = em.rd_next;
			if (em.eor) begin
				ph_d  = PH_FIRST;
				nte_d = 5'd0;
				gth_d = 64'd0;
				bg_d  = 4'd0;
				seq_d = SQ_FLUSH;
			end
		end
	end

	assign move_out = (em_fire && pend_valid_q) || flush_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q        <= SQ_IDLE;
			ph_q         <= PH_FIRST;
			pd_q         <= 16'd0;
			rd_q         <= 16'd0;
			prev_q       <= 32'd0;
			nte_q        <= 5'd0;
			gth_q        <= 64'd0;
			bg_q         <= 4'd0;
			bw_q         <= 8'd0;
			unp_cnt_q    <= 3'd0;
			unp_hi_q     <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			seq_q     <= seq_d;
			ph_q      <= ph_d;
			pd_q      <= pd_d;
			rd_q      <= rd_d;
			prev_q    <= prev_d;
			nte_q     <= nte_d;
			gth_q     <= gth_d;
			bg_q      <= bg_d;
			bw_q      <= bw_d;
			unp_cnt_q <= unp_cnt_d;
			unp_hi_q  <= unp_hi_d;
			if (em_fire) begin
				pend_valid_q <= 1'b1;
			end else if (flush_move) begin
				pend_valid_q <= 1'b0;
			end
			if (move_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		byte_q <= byte_d;
		if (code_we) begin
			codes_q[{unp_hi_q, unp_cnt_q}] <= ext_code;
		end
		if (em_fire) begin
			pend_pix_q <= em.value;
			pend_eor_q <= em.eor;
			pend_eoi_q <= em.eoi;
			pend_err_q <= em_err;
		end
		if (move_out) begin
			out_pix_q  <= pend_pix_q;
			out_eor_q  <= pend_eor_q;
			out_eoi_q  <= pend_eoi_q;
			out_err_q  <= pend_err_q;
			out_last_q <= flush_move;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pix_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_err_q, out_eoi_q, out_eor_q};

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !pend_valid_q)
		else $error("pending pixel left behind at idle");
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after an accepted beat");
	a_nte_range: assert property (@(posedge clk) disable iff (!arst_n)
		nte_q <= 5'(PAIR_SIZE))
		else $error("code index past pair end");
	a_gather_range: assert property (@(posedge clk) disable iff (!arst_n)
		bg_q <= 4'(BLOCK_SIZE))
		else $error("gather count past eight bytes");
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(em_fire && pend_valid_q) |-> out_free)
		else $error("pixel produced with no room downstream");

endmodule

### tb/sv/bpd_checker.sv
// Checker for the bit-packed delta decoder: predicts pixels from input beats and compares.
`timescale 1ns / 1ps
module bpd_checker import bpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tlast,
	input  logic [2:0]  m_tuser,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [31:0] value;
		logic        eor;
		logic        eoi;
		logic        last;
		logic        err;
	} pixel_t;

	pixel_t pixel_q[$];

	logic [15:0] width_reg, count_reg;
	phase_t      phase;
	logic [15:0] pix_done, row_done;
	logic [31:0] prev_pix;
	logic signed [8:0] codes[PAIR_SIZE];
	logic [4:0]  emit_idx;
	logic [63:0] gath;
	logic [3:0]  ngath;
	logic [7:0]  widths;
	int          nbeat_out;

	assign pending = pixel_q.size();

	function automatic logic [31:0] eff_width();
		return (width_reg == 0) ? 32'd1 : {16'd0, width_reg};
	endfunction

	function automatic void clr();
		gath = 0;
		ngath = 0;
	endfunction

	function automatic logic [3:0] clampw(logic [3:0] n);
		return (n > MAX_WIDTH) ? MAX_WIDTH : n;
	endfunction

	function automatic logic pair_bad();
		return (widths[3:0] > MAX_WIDTH) || (widths[7:4] > MAX_WIDTH);
	endfunction

	function automatic void pick_next();
		phase = ((eff_width() - pix_done) >= PAIR_SIZE) ? PH_WIDTH : PH_TAIL;
		clr();
	endfunction

	function automatic logic push_pixel(logic [31:0] v, logic err);
		pixel_t p;
		logic [31:0] cnt;
		p = '0;
		prev_pix = v;
		pix_done = pix_done + 16'd1;
		cnt = (count_reg == 0) ? 32'd1 : {16'd0, count_reg};
		if (pix_done >= eff_width()) begin
			p.eor = 1'b1;
			if ({16'd0, row_done} + 1 >= cnt) begin
				p.eoi = 1'b1;
				row_done = 0;
			end else begin
				row_done = row_done + 16'd1;
			end
			pix_done = 0;
			phase = PH_FIRST;
			emit_idx = 0;
			clr();
		end
		p.value = v;
		p.err = err;
		pixel_q.insert(pixel_q.size(), p);
		nbeat_out++;
		return p.eor;
	endfunction

	function automatic void unpack(int base, logic [3:0] n);
		int zero_at;
		logic [63:0] mask;
		logic [31:0] raw;
		zero_at = (n > 1) ? (1 << (n - 1)) - 1 : 0;
		mask = (64'd1 << n) - 1;
		for (int j = 0; j < BLOCK_SIZE; j++) begin
			raw = 32'((gath >> (n * j)) & mask);
			codes[base + j] = 9'(int'(raw) - zero_at);
		end
		clr();
	endfunction

	function automatic void run_pair();
		logic err;
		logic signed [8:0] c;
		err = pair_bad();
		while (emit_idx < PAIR_SIZE) begin
			c = codes[emit_idx[3:0]];
			if (c == CODE_OVF32) begin
				phase = PH_PAIR_S32;
				clr();
				return;
			end
			if (c == CODE_OVF16) begin
				phase = PH_PAIR_S16;
				clr();
				return;
			end
			emit_idx++;
			if (push_pixel(prev_pix + 32'(signed'(c)), err)) return;
		end
		emit_idx = 0;
		pick_next();
	endfunction

	function automatic void advance();
		if (phase == PH_BLOCK0 && ngath >= clampw(widths[3:0])) begin
			unpack(0, clampw(widths[3:0]));
			phase = PH_BLOCK1;
		end
		if (phase == PH_BLOCK1 && ngath >= clampw(widths[7:4])) begin
			unpack(BLOCK_SIZE, clampw(widths[7:4]));
			emit_idx = 0;
			run_pair();
		end
	endfunction

	function automatic logic take(logic [7:0] b, int need);
		gath |= 64'(b) << (8 * ngath[2:0]);
		ngath = ngath + 4'd1;
		return ngath >= need;
	endfunction

	function automatic logic [31:0] gathered(int need);
		logic [31:0] v;
		v = gath[31:0];
		if (need == 2) v = {{16{v[15]}}, v[15:0]};
		clr();
		return v;
	endfunction

	function automatic void decode_byte(logic [7:0] b, logic rs);
		int code, need;
		logic first;
		logic [31:0] v;
		nbeat_out = 0;
		if (rs) begin
			phase = PH_FIRST;
			pix_done = 0;
			emit_idx = 0;
			widths = 0;
			clr();
		end
		case (phase)
			PH_FIRST, PH_TAIL: begin
				code = int'(b) - 127;
				if (b == BYTE_ESC16) begin
					phase = (phase == PH_FIRST) ? PH_FIRST_S16 : PH_TAIL_S16;
					clr();
				end else if (b == BYTE_ESC32) begin
					phase = (phase == PH_FIRST) ? PH_FIRST_S32 : PH_TAIL_S32;
					clr();
				end else if (phase == PH_FIRST) begin
					if (!push_pixel(32'(code), 1'b0)) pick_next();
				end else begin
					if (!push_pixel(prev_pix + 32'(code), 1'b0)) pick_next();
				end
			end
			PH_FIRST_S16, PH_FIRST_S32, PH_TAIL_S16, PH_TAIL_S32: begin
				need = (phase == PH_FIRST_S16 || phase == PH_TAIL_S16) ? 2 : 4;
				first = (phase == PH_FIRST_S16 || phase == PH_FIRST_S32);
				if (take(b, need)) begin
					v = gathered(need);
					if (!push_pixel(first ? v : prev_pix + v, 1'b0)) pick_next();
				end
			end
			PH_WIDTH: begin
				widths = b;
				phase = PH_BLOCK0;
				clr();
				advance();
			end
			PH_BLOCK0, PH_BLOCK1: begin
				void'(take(b, 8));
				advance();
			end
			PH_PAIR_S16, PH_PAIR_S32: begin
				need = (phase == PH_PAIR_S16) ? 2 : 4;
				if (take(b, need)) begin
					v = gathered(need);
					phase = PH_BLOCK1;
					emit_idx++;
					if (!push_pixel(prev_pix + v, pair_bad())) run_pair();
				end
			end
			default: begin
				phase = PH_FIRST;
				clr();
			end
		endcase
		if (nbeat_out > 0) pixel_q[pixel_q.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_t e;
		int errs;
		if (!arst_n) begin
			width_reg <= DIM_RESET;
			count_reg <= DIM_RESET;
			phase = PH_FIRST;
			pix_done = 0;
			row_done = 0;
			prev_pix = 0;
			emit_idx = 0;
			widths = 0;
			clr();
			for (int i = 0; i < PAIR_SIZE; i++) codes[i] = 0;
			pixel_q.delete();
			fail_count <= 0;
		end else begin
			errs = 0;
			if (psel && penable && pwrite) begin
				if (paddr[2] == REG_ROW_WIDTH) width_reg <= pwdata[15:0];
				else count_reg <= pwdata[15:0];
			end
			if (m_tvalid && m_tready) begin
				if (pixel_q.size() == 0) begin
					$error("unexpected pixel beat %h", m_tdata);
					errs++;
				end else begin
					e = pixel_q.pop_front();
					if (m_tdata !== e.value) begin
						$error("pixel_value exp %h got %h", e.value, m_tdata);
						errs++;
					end
					if (m_tuser[0] !== e.eor) begin
						$error("end_of_row exp %b got %b", e.eor, m_tuser[0]);
						errs++;
					end
					if (m_tuser[1] !== e.eoi) begin
						$error("end_of_image exp %b got %b", e.eoi, m_tuser[1]);
						errs++;
					end
					if (m_tlast !== e.last) begin
						$error("last_of_run exp %b got %b", e.last, m_tlast);
						errs++;
					end
					if (m_tuser[2] !== e.err) begin
						$error("format_error exp %b got %b", e.err, m_tuser[2]);
						errs++;
					end
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
			if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser);
		end
	end

endmodule

### tb/sv/tb_block_bitpacked_delta_decoder_unit.sv
// Testbench top of the bit-packed delta decoder: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb_block_bitpacked_delta_decoder_unit import bpd_pkg::*; ();

	logic        clk, arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        s_tvalid, s_tready, s_tuser;
	logic [7:0]  s_tdata;
	logic        m_tvalid, m_tready, m_tlast;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	int          fail_count, pending, cycles;
	bit          stall_en;

	localparam int CYCLE_LIMIT = 2000000;

	block_bitpacked_delta_decoder_unit dut (.*);

	bpd_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
	endfunction

	initial begin
		int g;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			g = (stall_en && $urandom_range(0, 3) == 0) ? gap_len() : 0;
			if (g > 0) begin
				m_tready <= 0;
				repeat (g) @(posedge clk);
			end
			m_tready <= 1;
		end
	end

	task automatic cfg_write(logic reg_sel, logic [15:0] val);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= {16'd0, val};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic send(logic [7:0] b, logic rs);
		int g;
		g = (stall_en && $urandom_range(0, 3) == 0) ? gap_len() : 0;
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= b;
		s_tuser <= rs;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic go_idle();
		@(posedge clk);
		s_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// random first or tail byte code, with escapes
	task automatic send_code(logic rs);
		int k;
		k = $urandom_range(0, 5);
		if (k == 0) begin
			send(BYTE_ESC16, rs);
			send(8'($urandom), 0);
			send(8'($urandom), 0);
		end else if (k == 1) begin
			send(BYTE_ESC32, rs);
			repeat (4) send(8'($urandom), 0);
		end else begin
			send(8'($urandom_range(0, 253)), rs);
		end
	endtask

	// one pair: width byte, code bytes, random extra bytes when a block has width eight
	task automatic send_pair(logic [7:0] wb);
		int n0, n1;
		logic [63:0] pk;
		int nb[2];
		n0 = (wb[3:0] > 8) ? 8 : wb[3:0];
		n1 = (wb[7:4] > 8) ? 8 : wb[7:4];
		nb[0] = n0;
		nb[1] = n1;
		send(wb, 0);
		for (int blk = 0; blk < 2; blk++) begin
			pk = {$urandom, $urandom};
			for (int i = 0; i < nb[blk]; i++) send(pk[8*i +: 8], 0);
		end
		// overflow words: supply generous random bytes; extras start the next section
		if (n0 == 8 || n1 == 8) repeat ($urandom_range(0, 8)) send(8'($urandom), 0);
	endtask

	task automatic send_row(int w, logic rs);
		int pairs, tail;
		pairs = (w - 1) / PAIR_SIZE;
		tail = (w - 1) % PAIR_SIZE;
		send_code(rs);
		for (int p = 0; p < pairs; p++) begin
			case ($urandom_range(0, 5))
				0: send_pair(8'h88);
				1: send_pair({4'($urandom_range(9, 15)), 4'($urandom_range(0, 8))});
				default: send_pair({4'($urandom_range(0, 7)), 4'($urandom_range(0, 7))});
			endcase
		end
		for (int t = 0; t < tail; t++) send_code(0);
	endtask

	initial begin
		int w, nrows;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		stall_en = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;

		cfg_write(REG_ROW_WIDTH, 16'd33);
		cfg_write(REG_ROW_COUNT, 16'd2);
		// directed: extremes, escapes, zero and over-range widths, overflow codes
		send(8'd0, 1);
		send(8'd253, 0);
		send(8'h00, 0);
		send(8'hFF, 0);
		send(BYTE_ESC32, 0); repeat (4) send(8'hFF, 0);
		send(8'h8F, 0); repeat (16) send(8'hFF, 0);
		send(8'd127, 1);
		send(8'h11, 0); send(8'hFF, 0); send(8'h00, 0);
		send(8'hFF, 0); send(8'h7F, 0);
		go_idle();

		cfg_write(REG_ROW_WIDTH, 16'd0);
		cfg_write(REG_ROW_COUNT, 16'd0);
		send(BYTE_ESC16, 1); send(8'h00, 0); send(8'h80, 0);
		send(8'd5, 0);
		go_idle();

		stall_en = 1;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					w = 20; nrows = 4;
					cfg_write(REG_ROW_WIDTH, 16'd20); cfg_write(REG_ROW_COUNT, 16'd3);
				end
				1: begin
					w = 1; nrows = 8;
					cfg_write(REG_ROW_WIDTH, 16'd1); cfg_write(REG_ROW_COUNT, 16'd65535);
				end
				2: begin
					w = 49; nrows = 3;
					cfg_write(REG_ROW_WIDTH, 16'd49); cfg_write(REG_ROW_COUNT, 16'd1);
				end
				default: begin
					w = 65535; nrows = 1;
					cfg_write(REG_ROW_WIDTH, 16'hFFFF); cfg_write(REG_ROW_COUNT, 16'd4);
				end
			endcase
			for (int r = 0; r < nrows; r++) begin
				if ($urandom_range(0, 7) == 0)
					repeat ($urandom_range(1, 6)) send(8'($urandom), 1'($urandom));
				if (ph == 3) begin
					repeat (100) send(8'($urandom), 0);
				end else begin
					send_row(w, $urandom_range(0, 3) != 0);
				end
			end
			go_idle();
		end

		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### block_bitpacked_delta_decoder_unit.f
rtl/bpd_pkg.sv
rtl/bpd_unpack_shift.sv
rtl/bpd_emit.sv
rtl/block_bitpacked_delta_decoder_unit.sv
tb/sv/bpd_checker.sv
tb/sv/tb_block_bitpacked_delta_decoder_unit.sv
